// ----- hw/rtl/fifo_elevator_controller_defines.svh -----
// Assertion macros shared by the elevator controller checker.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef FIFO_ELEVATOR_CONTROLLER_DEFINES_SVH
`define FIFO_ELEVATOR_CONTROLLER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define FELEV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define FELEV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/felev_pkg.sv -----
// Shared constants and helpers for the elevator controller.
// No dependencies; used by the interfaces, the top level and the checker.
package felev_pkg;

  localparam int LEVEL_W         = 2;
  localparam int LAMP_W          = 3;
  localparam int ENTRY_W         = 2 * LEVEL_W;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam logic [LEVEL_W-1:0] LVL_LOWER  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_MIDDLE = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_UPPER  = 2'd2;

  localparam logic KIND_STEP    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic [LAMP_W-1:0] LAMP_LOWER  = 3'b001;
  localparam logic [LAMP_W-1:0] LAMP_MIDDLE = 3'b010;
  localparam logic [LAMP_W-1:0] LAMP_UPPER  = 3'b100;

  // Clamp level code three to the upper level.
  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
    return (v > LVL_UPPER) ? LVL_UPPER : v;
  endfunction

  // Advance one level toward the target.
  function automatic logic [LEVEL_W-1:0] step_toward(input logic [LEVEL_W-1:0] from,
                                                     input logic [LEVEL_W-1:0] to);
    return (from < to) ? LEVEL_W'(from + 1'b1) : LEVEL_W'(from - 1'b1);
  endfunction

  function automatic logic [LAMP_W-1:0] level_lamps(input logic [LEVEL_W-1:0] lvl);
    logic [LAMP_W-1:0] lamps;
    case (lvl)
      LVL_LOWER:  lamps = LAMP_LOWER;
      LVL_MIDDLE: lamps = LAMP_MIDDLE;
      LVL_UPPER:  lamps = LAMP_UPPER;
      default:    lamps = '0;
    endcase
    return lamps;
  endfunction

endpackage

// ----- hw/rtl/felev_ifs.sv -----
// Valid/ready channel interfaces for the elevator controller.
// Depends on felev_pkg for field widths.
interface felev_in_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [felev_pkg::LEVEL_W-1:0]   origin;
  logic [felev_pkg::LEVEL_W-1:0]   destination;

  modport source (output valid, kind, origin, destination, input ready);
  modport sink   (input valid, kind, origin, destination, output ready);
endinterface

interface felev_out_if #(
  parameter int QUEUED_W = $clog2(felev_pkg::QUEUE_DEPTH_DEF + 1)
);
  logic                            valid;
  logic                            ready;
  logic [felev_pkg::LEVEL_W-1:0]   level;
  logic [felev_pkg::LAMP_W-1:0]    level_lamps;
  logic                            busy_res;
  logic                            moved;
  logic                            trip_done;
  logic                            accepted;
  logic [QUEUED_W-1:0]             queued;

  modport source (output valid, level, level_lamps, busy_res, moved, trip_done, accepted,
                  queued, input ready);
  modport sink   (input valid, level, level_lamps, busy_res, moved, trip_done, accepted,
                  queued, output ready);
endinterface

// ----- hw/rtl/felev_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module felev_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/fifo_elevator_controller.sv -----
// Three-level elevator controller with a first-come trip request queue.
// Depends on felev_pkg, felev_ifs (channel interfaces) and felev_ram.
//
// Usage:
//   in_ch  carries one control step per transaction; kind set means the step
//          also carries a trip request (origin, destination).
//   out_ch carries exactly one result per step: car level, lamps, busy flag,
//          moved flag, trip completion, request acceptance and queue fill.
// Result: a step accepted at an edge shows its result from that edge on the
//   output register, in the cycle after the step is taken.
// Throughput: one step per cycle while the output register is not stalled.
//   The whole step (queue push, car move, queue pop) resolves in one pass of
//   logic ahead of the result register. The queue head comes from the RAM's
//   registered read, prefetched every cycle at the next read pointer, with a bypass for a same-cycle write.
// Stall: a result waits in the output register while out_ch.ready is low;
//   in_ch.ready stays high as long as that register is empty or draining.
// Reset: rst_n (synchronous, active low) empties the queue, parks the car at
//   the lower level, idles the controller and drops any pending result.
//   The request RAM is not cleared; entries are read only once written.
module fifo_elevator_controller #(
  parameter int QUEUE_DEPTH = felev_pkg::QUEUE_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  felev_in_if.sink     in_ch,
  felev_out_if.source  out_ch
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LW    = felev_pkg::LEVEL_W;
  localparam int EW    = felev_pkg::ENTRY_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Queue and car state
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic             serving_r, serving_nxt;
  logic             picked_r, picked_nxt;

  // Head bypass for a write that lands on the address being prefetched
  logic             byp_r, byp_nxt;
  logic [EW-1:0]    byp_data_r;

  // Result register
  logic             out_valid_r;
  logic [LW-1:0]    res_level_r;
  logic             res_busy_r;
  logic             res_moved_r, res_moved_nxt;
  logic             res_done_r, res_done_nxt;
  logic             res_acc_r;

  logic             fire;
  logic             push;
  logic [EW-1:0]    entry_in;
  logic [EW-1:0]    ram_rdata;
  logic [EW-1:0]    head;
  logic [LW-1:0]    head_org;
  logic [LW-1:0]    head_dst;
  logic             serving_a;
  logic             picked_a;
  logic [CNT_W-1:0] fill_a;
  logic [LW-1:0]    level_a;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  // Saturate level code three; origin in the low bits, destination above.
  assign entry_in = {felev_pkg::sat_level(in_ch.destination),
                     felev_pkg::sat_level(in_ch.origin)};
  assign push     = (in_ch.kind == felev_pkg::KIND_REQUEST) && (fill_r != CNT_FULL);

  // An empty queue before the push means the head is the request being pushed.
  assign head     = (fill_r == '0) ? entry_in : (byp_r ? byp_data_r : ram_rdata);
  assign head_org = head[LW-1:0];
  assign head_dst = head[EW-1:LW];

  always_comb begin
    // Push first
    fill_a    = push ? CNT_W'(fill_r + 1'b1) : fill_r;
    serving_a = serving_r || push;
    picked_a  = (push && !serving_r) ? 1'b0 : picked_r;
    wp_nxt    = wp_r;
    if (fire && push) begin
      wp_nxt = (wp_r == PTR_LAST) ? '0 : PTR_W'(wp_r + 1'b1);
    end

    // Then move the car
    level_a       = level_r;
    rp_nxt        = rp_r;
    fill_nxt      = fill_a;
    serving_nxt   = serving_a;
    picked_nxt    = picked_a;
    res_moved_nxt = 1'b0;
    res_done_nxt  = 1'b0;
    if (serving_a) begin
      if (fill_a == '0) begin
        serving_nxt = 1'b0;
        picked_nxt  = 1'b0;
      end else begin
        if (!picked_a && (level_r != head_org)) begin
          level_a       = felev_pkg::step_toward(level_r, head_org);
          res_moved_nxt = 1'b1;
        end else begin
          picked_nxt = 1'b1;
          if (level_r != head_dst) begin
            level_a       = felev_pkg::step_toward(level_r, head_dst);
            res_moved_nxt = 1'b1;
          end else begin
            // Arrived: pop the head request
            rp_nxt       = (rp_r == PTR_LAST) ? '0 : PTR_W'(rp_r + 1'b1);
            fill_nxt     = CNT_W'(fill_a - 1'b1);
            picked_nxt   = 1'b0;
            res_done_nxt = 1'b1;
            if (fill_nxt == '0) begin
              serving_nxt = 1'b0;
            end
          end
        end
      end
    end
    level_nxt = level_a;

    // Hold everything when no transaction is taken
    if (!fire) begin
      rp_nxt      = rp_r;
      fill_nxt    = fill_r;
      serving_nxt = serving_r;
      picked_nxt  = picked_r;
      level_nxt   = level_r;
    end
  end

  // Prefetch the next head every cycle; bypass if this cycle writes that entry.
  assign byp_nxt = fire && push && (wp_r == rp_nxt);

  felev_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (fire && push),
    .waddr (wp_r),
    .wdata (entry_in),
    .raddr (rp_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      level_r     <= felev_pkg::LVL_LOWER;
      serving_r   <= 1'b0;
      picked_r    <= 1'b0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rp_r      <= rp_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      level_r   <= level_nxt;
      serving_r <= serving_nxt;
      picked_r  <= picked_nxt;
      byp_r     <= byp_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: load on every taken step, hold otherwise; the bypass data register loads every cycle.
  always_ff @(posedge clk) begin
    byp_data_r <= entry_in;
    if (fire) begin
      res_level_r <= level_nxt;
      res_busy_r  <= serving_nxt;
      res_moved_r <= res_moved_nxt;
      res_done_r  <= res_done_nxt;
      res_acc_r   <= push;
    end
  end

  logic [CNT_W-1:0] queued_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      queued_r <= fill_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.level       = res_level_r;
  assign out_ch.level_lamps = felev_pkg::level_lamps(res_level_r);
  assign out_ch.busy_res    = res_busy_r;
  assign out_ch.moved       = res_moved_r;
  assign out_ch.trip_done   = res_done_r;
  assign out_ch.accepted    = res_acc_r;
  assign out_ch.queued      = queued_r;

endmodule

// ----- hw/rtl/felev_chk.sv -----
// Port-level checker for the elevator controller, bound to the top level.
// Depends on felev_pkg and fifo_elevator_controller_defines.svh.
`include "fifo_elevator_controller_defines.svh"

module felev_chk #(
  parameter int QUEUE_DEPTH = felev_pkg::QUEUE_DEPTH_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [felev_pkg::LEVEL_W-1:0]      out_level,
  input logic [felev_pkg::LAMP_W-1:0]       out_level_lamps,
  input logic                               out_busy_res,
  input logic                               out_moved,
  input logic                               out_trip_done,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_queued
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Lamps follow the reported level.
  `FELEV_ASSERT_NOW(a_lamps_match, out_valid, (out_level == felev_pkg::LVL_LOWER && out_level_lamps == felev_pkg::LAMP_LOWER) || (out_level == felev_pkg::LVL_MIDDLE && out_level_lamps == felev_pkg::LAMP_MIDDLE) || (out_level == felev_pkg::LVL_UPPER && out_level_lamps == felev_pkg::LAMP_UPPER), "lamps disagree with level")

  // Busy exactly while requests wait, and never beyond capacity.
  `FELEV_ASSERT_NOW(a_busy_fill, out_valid, (out_busy_res == (out_queued != '0)) && (out_queued <= CNT_W'(QUEUE_DEPTH)), "busy flag or fill count inconsistent")

  // A completed trip never moves the car in the same step.
  `FELEV_ASSERT_NOW(a_done_still, out_valid, !(out_moved && out_trip_done), "trip completed while moving")

  // A stalled result holds.
  `FELEV_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_level) && $stable(out_queued), "stalled result changed")

endmodule

bind fifo_elevator_controller felev_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_felev_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_level       (out_ch.level),
  .out_level_lamps (out_ch.level_lamps),
  .out_busy_res    (out_ch.busy_res),
  .out_moved       (out_ch.moved),
  .out_trip_done   (out_ch.trip_done),
  .out_queued      (out_ch.queued)
);
